FILE: rtl/lsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Line fit package
// Shared constants, widths and the CORDIC arctangent table for the line fit.
// ----------------------------------------------------------------------------
package lsf_pkg;

   localparam int MAX_POINTS_DEF = 256;
   localparam int IN_W           = 16;
   localparam int SUM_W          = 25;
   localparam int SQ_W           = 41;
   localparam int WIDE_W         = 64;
   localparam int RES_W          = 32;
   localparam int ANG_W          = 24;
   localparam int USED_W         = 9;
   localparam int FRAC_W         = 5;
   localparam int CORDIC_STEPS   = 20;

   localparam logic [FRAC_W-1:0] SLOPE_FRAC = 5'd16;
   localparam logic [FRAC_W-1:0] ICPT_FRAC  = 5'd8;
   localparam logic signed [24:0] ANGLE_LIMIT = 25'sd5898240;

   function automatic logic [21:0] atan_q16(input logic [4:0] idx);
      logic [21:0] val;
      unique case (idx)
         5'd0:    val = 22'd2949120;
         5'd1:    val = 22'd1740967;
         5'd2:    val = 22'd919879;
         5'd3:    val = 22'd466945;
         5'd4:    val = 22'd234379;
         5'd5:    val = 22'd117304;
         5'd6:    val = 22'd58666;
         5'd7:    val = 22'd29335;
         5'd8:    val = 22'd14668;
         5'd9:    val = 22'd7334;
         5'd10:   val = 22'd3667;
         5'd11:   val = 22'd1833;
         5'd12:   val = 22'd917;
         5'd13:   val = 22'd458;
         5'd14:   val = 22'd229;
         5'd15:   val = 22'd115;
         5'd16:   val = 22'd57;
         5'd17:   val = 22'd29;
         5'd18:   val = 22'd14;
         5'd19:   val = 22'd7;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/least_squares_line_fit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Least-squares line fit
// Fits y = a*x + b over a batch of points and reports slope, intercept and
// line angle.
//
// An item is one Q7.8 point on req_x_pos and req_y_pos, taken when start is
// high and busy is low. The point is summed into x and y on acceptance, into
// x*x in S_ACC_XX and into x*y in S_ACC_XY; points beyond MAX_POINTS are
// dropped but still count as items. When req_last_point is set, the fit runs
// on one shared serial multiplier (six products), a bit-serial divider (for
// the slope and then the intercept) and a 20-step CORDIC. Busy stays high
// until the result is issued, also when the denominator is zero.
// The result appears for one cycle with rsp_strobe high; the receiver cannot
// stall it. A zero denominator gives rsp_fit_valid low and zero values.
// After the result all sums and the point count are cleared. Reset clears
// the sums, the count and the sequencer, and the block is ready at once.
// ----------------------------------------------------------------------------
module least_squares_line_fit #(
   parameter int MAX_POINTS = lsf_pkg::MAX_POINTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_x_pos,
   input  wire logic [15:0] req_y_pos,
   input  wire logic        req_last_point,
   output logic             rsp_strobe,
   output logic             rsp_fit_valid,
   output logic [31:0]      rsp_slope,
   output logic [31:0]      rsp_intercept,
   output logic [23:0]      rsp_angle_deg,
   output logic [8:0]       rsp_points_used
);
   import lsf_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_ACC_XX, S_ACC_XY, S_MUL_GO, S_MUL_WAIT,
      S_DIV_GO, S_DIV_WAIT, S_COR_GO, S_COR_WAIT
   } state_type;

   state_type                state_ff, state_in;
   logic signed [SUM_W-1:0]  acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic signed [SQ_W-1:0]   acc_xx_ff, acc_xx_in, acc_xy_ff, acc_xy_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [IN_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic                     last_ff, last_in, add_ff, add_in;
   logic [2:0]               idx_ff, idx_in;
   logic [WIDE_W-1:0]        tmp_ff, tmp_in, den_ff, den_in, num_ff, num_in;
   logic [RES_W-1:0]         slope_ff, slope_in, icpt_ff, icpt_in;
   logic                     strobe_ff, strobe_in, valid_ff, valid_in;
   logic [RES_W-1:0]         oslope_ff, oslope_in, oicpt_ff, oicpt_in;
   logic [ANG_W-1:0]         oang_ff, oang_in;
   logic [USED_W-1:0]        oused_ff, oused_in;

   logic                     accept;
   logic signed [IN_W-1:0]   mop;
   logic signed [31:0]       sq;
   logic [WIDE_W-1:0]        n64, sx64, sy64, sxx64, sxy64, op_a, op_b, diff;
   logic                     mul_done, div_done, cor_done;
   logic [WIDE_W-1:0]        product;
   logic [RES_W-1:0]         quot;
   logic [ANG_W-1:0]         angle;
   logic [FRAC_W-1:0]        frac;

   assign busy   = state_ff != S_IDLE;
   assign accept = start && !busy;

   assign n64   = WIDE_W'(count_ff);
   assign sx64  = {{(WIDE_W-SUM_W){acc_x_ff[SUM_W-1]}}, acc_x_ff};
   assign sy64  = {{(WIDE_W-SUM_W){acc_y_ff[SUM_W-1]}}, acc_y_ff};
   assign sxx64 = {{(WIDE_W-SQ_W){acc_xx_ff[SQ_W-1]}}, acc_xx_ff};
   assign sxy64 = {{(WIDE_W-SQ_W){acc_xy_ff[SQ_W-1]}}, acc_xy_ff};
   assign diff  = tmp_ff - product;
   assign frac  = (idx_ff == 3'd3) ? SLOPE_FRAC : ICPT_FRAC;

   always_comb begin
      unique case (idx_ff)
         3'd0:    begin op_a = n64;   op_b = sxx64; end
         3'd1:    begin op_a = sx64;  op_b = sx64;  end
         3'd2:    begin op_a = n64;   op_b = sxy64; end
         3'd3:    begin op_a = sx64;  op_b = sy64;  end
         3'd4:    begin op_a = sxx64; op_b = sy64;  end
         default: begin op_a = sx64;  op_b = sxy64; end
      endcase
   end

   assign mop = (state_ff == S_ACC_XX) ? x_ff : y_ff;
   assign sq  = x_ff * mop;

   lsf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == S_MUL_GO),
      .op_a    (op_a),
      .op_b    (op_b),
      .done    (mul_done),
      .product (product)
   );

   lsf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_DIV_GO),
      .frac  (frac),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (quot)
   );

   lsf_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_COR_GO),
      .slope (slope_ff),
      .done  (cor_done),
      .angle (angle)
   );

   always_comb begin
      logic emit;
      logic emit_valid;
      emit       = 1'b0;
      emit_valid = 1'b0;

      state_in  = state_ff;
      acc_x_in  = acc_x_ff;
      acc_y_in  = acc_y_ff;
      acc_xx_in = acc_xx_ff;
      acc_xy_in = acc_xy_ff;
      count_in  = count_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      last_in   = last_ff;
      add_in    = add_ff;
      idx_in    = idx_ff;
      tmp_in    = tmp_ff;
      den_in    = den_ff;
      num_in    = num_ff;
      slope_in  = slope_ff;
      icpt_in   = icpt_ff;
      strobe_in = 1'b0;
      valid_in  = valid_ff;
      oslope_in = oslope_ff;
      oicpt_in  = oicpt_ff;
      oang_in   = oang_ff;
      oused_in  = oused_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               x_in    = req_x_pos;
               y_in    = req_y_pos;
               last_in = req_last_point;
               add_in  = count_ff < CNT_W'(MAX_POINTS);
               if (count_ff < CNT_W'(MAX_POINTS)) begin
                  acc_x_in = acc_x_ff + SUM_W'($signed(req_x_pos));
                  acc_y_in = acc_y_ff + SUM_W'($signed(req_y_pos));
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = S_ACC_XX;
            end
         end
         S_ACC_XX: begin
            if (add_ff) begin
               acc_xx_in = acc_xx_ff + SQ_W'(sq);
            end
            state_in = S_ACC_XY;
         end
         S_ACC_XY: begin
            if (add_ff) begin
               acc_xy_in = acc_xy_ff + SQ_W'(sq);
            end
            idx_in   = '0;
            state_in = last_ff ? S_MUL_GO : S_IDLE;
         end
         S_MUL_GO: begin
            state_in = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (mul_done) begin
               if (!idx_ff[0]) begin
                  tmp_in   = product;
                  idx_in   = idx_ff + 3'd1;
                  state_in = S_MUL_GO;
               end else if (idx_ff == 3'd1) begin
                  den_in = diff;
                  if (diff == '0) begin
                     emit = 1'b1;
                  end else begin
                     idx_in   = 3'd2;
                     state_in = S_MUL_GO;
                  end
               end else begin
                  num_in   = diff;
                  state_in = S_DIV_GO;
               end
            end
         end
         S_DIV_GO: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               if (idx_ff == 3'd3) begin
                  slope_in = quot;
                  idx_in   = 3'd4;
                  state_in = S_MUL_GO;
               end else begin
                  icpt_in  = quot;
                  state_in = S_COR_GO;
               end
            end
         end
         S_COR_GO: begin
            state_in = S_COR_WAIT;
         end
         S_COR_WAIT: begin
            if (cor_done) begin
               emit       = 1'b1;
               emit_valid = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (emit) begin
         strobe_in = 1'b1;
         valid_in  = emit_valid;
         oslope_in = emit_valid ? slope_ff : '0;
         oicpt_in  = emit_valid ? icpt_ff : '0;
         oang_in   = emit_valid ? angle : '0;
         oused_in  = USED_W'(count_ff);
         acc_x_in  = '0;
         acc_y_in  = '0;
         acc_xx_in = '0;
         acc_xy_in = '0;
         count_in  = '0;
         state_in  = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         acc_x_ff  <= '0;
         acc_y_ff  <= '0;
         acc_xx_ff <= '0;
         acc_xy_ff <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         acc_x_ff  <= acc_x_in;
         acc_y_ff  <= acc_y_in;
         acc_xx_ff <= acc_xx_in;
         acc_xy_ff <= acc_xy_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      x_ff      <= x_in;
      y_ff      <= y_in;
      last_ff   <= last_in;
      add_ff    <= add_in;
      idx_ff    <= idx_in;
      tmp_ff    <= tmp_in;
      den_ff    <= den_in;
      num_ff    <= num_in;
      slope_ff  <= slope_in;
      icpt_ff   <= icpt_in;
      valid_ff  <= valid_in;
      oslope_ff <= oslope_in;
      oicpt_ff  <= oicpt_in;
      oang_ff   <= oang_in;
      oused_ff  <= oused_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_fit_valid   = valid_ff;
   assign rsp_slope       = oslope_ff;
   assign rsp_intercept   = oicpt_ff;
   assign rsp_angle_deg   = oang_ff;
   assign rsp_points_used = oused_ff;

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result issued while the sequencer is still running");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_fit_valid) |->
         (rsp_slope == '0 && rsp_intercept == '0 && rsp_angle_deg == '0))
      else $error("invalid fit carries nonzero values");

   a_cleared_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (count_ff == '0 && acc_x_ff == '0 && acc_xx_ff == '0))
      else $error("sums not cleared after a result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count exceeds the batch limit");

endmodule
`default_nettype wire

FILE: rtl/lsf_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add product of two 64-bit words modulo 2^64, one bit per cycle.
// ----------------------------------------------------------------------------
module lsf_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] op_a,
   input  wire logic [63:0] op_b,
   output logic             done,
   output logic [63:0]      product
);
   import lsf_pkg::*;

   logic [WIDE_W-1:0] a_ff, a_in, b_ff, b_in, p_ff, p_in;
   logic              run_ff, run_in, done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      p_in    = p_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = op_a;
         b_in   = op_b;
         p_in   = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (b_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) begin
               p_in = p_ff + a_ff;
            end
            a_in = {a_ff[WIDE_W-2:0], 1'b0};
            b_in = {1'b0, b_ff[WIDE_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      p_ff <= p_in;
   end

   assign done    = done_ff;
   assign product = p_ff;

endmodule
`default_nettype wire

FILE: rtl/lsf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial fixed-point divider
// Signed 64-bit quotient scaled by 2^frac, rounded half away from zero and
// saturated to 32 bits, by restoring division one bit per cycle.
// ----------------------------------------------------------------------------
module lsf_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [lsf_pkg::FRAC_W-1:0] frac,
   input  wire logic [63:0]               num,
   input  wire logic [63:0]               den,
   output logic                           done,
   output logic [31:0]                    quot
);
   import lsf_pkg::*;

   typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_type;

   dstate_type        state_ff, state_in;
   logic [WIDE_W-1:0] ad_ff, ad_in, nsh_ff, nsh_in, r_ff, r_in, q_ff, q_in;
   logic              neg_ff, neg_in, done_ff, done_in;
   logic [6:0]        cnt_ff, cnt_in, last_ff, last_in;
   logic [RES_W-1:0]  thr_ff, thr_in, quot_ff, quot_in;
   logic [WIDE_W:0]   rs, rdiff;
   logic              ge, rnd;
   logic [WIDE_W-1:0] limit, mag, res;

   always_comb begin
      rs    = {r_ff, nsh_ff[WIDE_W-1]};
      rdiff = rs - {1'b0, ad_ff};
      ge    = rs >= {1'b0, ad_ff};
      limit = neg_ff ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
      rnd   = {r_ff, 1'b0} >= {1'b0, ad_ff};
      mag   = q_ff + {63'd0, rnd};
      if (mag > limit) begin
         mag = limit;
      end
      res = neg_ff ? (64'd0 - mag) : mag;

      state_in = state_ff;
      ad_in    = ad_ff;
      nsh_in   = nsh_ff;
      r_in     = r_ff;
      q_in     = q_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      thr_in   = thr_ff;
      quot_in  = quot_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               neg_in   = num[WIDE_W-1] ^ den[WIDE_W-1];
               nsh_in   = num[WIDE_W-1] ? (64'd0 - num) : num;
               ad_in    = den[WIDE_W-1] ? (64'd0 - den) : den;
               r_in     = '0;
               q_in     = '0;
               cnt_in   = '0;
               last_in  = 7'd63 + {2'b00, frac};
               thr_in   = 32'h8000_0000 >> frac;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            if (cnt_ff == 7'd64 && q_ff > {32'd0, thr_ff}) begin
               quot_in  = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               r_in   = ge ? rdiff[WIDE_W-1:0] : rs[WIDE_W-1:0];
               q_in   = {q_ff[WIDE_W-2:0], ge};
               nsh_in = {nsh_ff[WIDE_W-2:0], 1'b0};
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff == last_ff) begin
                  state_in = D_FIN;
               end
            end
         end
         D_FIN: begin
            quot_in  = res[RES_W-1:0];
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      ad_ff   <= ad_in;
      nsh_ff  <= nsh_in;
      r_ff    <= r_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      last_ff <= last_in;
      thr_ff  <= thr_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

FILE: rtl/lsf_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC arctangent
// Vectoring CORDIC on (1.0, slope) giving the angle in Q16 degrees,
// one rotation per cycle, clamped to plus or minus ninety degrees.
// ----------------------------------------------------------------------------
module lsf_cordic (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] slope,
   output logic             done,
   output logic [23:0]      angle
);
   import lsf_pkg::*;

   logic signed [43:0] x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [24:0] z_ff, z_in, tab, zc;
   logic [4:0]         i_ff, i_in;
   logic               run_ff, run_in, done_ff, done_in;
   logic [ANG_W-1:0]   angle_ff, angle_in;

   always_comb begin
      dx  = x_ff >>> i_ff;
      dy  = y_ff >>> i_ff;
      tab = $signed({3'b000, atan_q16(i_ff)});

      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      i_in     = i_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      angle_in = angle_ff;
      if (!y_ff[43]) begin
         x_in = x_ff + dy;
         y_in = y_ff - dx;
         z_in = z_ff + tab;
      end else begin
         x_in = x_ff - dy;
         y_in = y_ff + dx;
         z_in = z_ff - tab;
      end
      zc = z_in;
      if (z_in > ANGLE_LIMIT) begin
         zc = ANGLE_LIMIT;
      end else if (z_in < -ANGLE_LIMIT) begin
         zc = -ANGLE_LIMIT;
      end
      i_in = i_ff + 5'd1;

      if (start) begin
         x_in = 44'sd16777216;
         y_in = $signed({{4{slope[31]}}, slope, 8'd0});
         z_in = '0;
         i_in = '0;
         if (slope == '0) begin
            angle_in = '0;
            done_in  = 1'b1;
            run_in   = 1'b0;
         end else begin
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         if (i_ff == 5'(CORDIC_STEPS - 1)) begin
            angle_in = zc[ANG_W-1:0];
            done_in  = 1'b1;
            run_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      i_ff     <= i_in;
      angle_ff <= angle_in;
   end

   assign done  = done_ff;
   assign angle = angle_ff;

endmodule
`default_nettype wire
